// ----- rtl/hsfd_pkg.sv -----
// Shared types, constants and CRC helper for the humidity sensor frame decoder.
package hsfd_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 15;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CHECK_CRC,
    CFG_TEMP_FLOOR,
    CFG_TEMP_CEILING,
    CFG_HUMID_FLOOR,
    CFG_HUMID_CEILING
  } cfg_idx_t;

  // Byte positions inside the six-byte frame
  localparam logic [2:0] POS_TEMP_HI   = 3'd0;
  localparam logic [2:0] POS_TEMP_LO   = 3'd1;
  localparam logic [2:0] POS_TEMP_CRC  = 3'd2;
  localparam logic [2:0] POS_HUMID_HI  = 3'd3;
  localparam logic [2:0] POS_HUMID_LO  = 3'd4;
  localparam logic [2:0] POS_HUMID_CRC = 3'd5;

  localparam logic [7:0] CRC_INIT = 8'hFF;
  localparam logic [7:0] CRC_POLY = 8'h31;

  // Fixed-point conversion constants
  localparam int unsigned TEMP_SCALE   = 17500;
  localparam int unsigned TEMP_OFFSET  = 4500;
  localparam int unsigned HUMID_SCALE  = 10000;
  localparam int unsigned F_OFFSET     = 3200;
  localparam int unsigned DIV5_RECIP   = 52429;  // ceil(2^18 / 5)
  localparam int unsigned DIV5_SHIFT   = 18;

  localparam int unsigned MID_DEPTH_DEF = 2;
  localparam int unsigned OUT_DEPTH_DEF = 8;

  typedef struct packed {
    logic               check_crc;
    logic signed [14:0] temp_floor;
    logic signed [14:0] temp_ceiling;
    logic        [13:0] humid_floor;
    logic        [13:0] humid_ceiling;
  } hsfd_cfg_t;

  localparam hsfd_cfg_t CFG_RESET = '{
    check_crc:     1'b1,
    temp_floor:    -15'sd4000,
    temp_ceiling:  15'sd12500,
    humid_floor:   14'd0,
    humid_ceiling: 14'd10000
  };

  typedef struct packed {
    logic        bad;
    logic [15:0] temp_word;
    logic [15:0] humid_word;
  } hsfd_frame_t;

  typedef struct packed {
    logic               status;
    logic        [15:0] temp_ticks;
    logic        [15:0] humid_ticks;
    logic signed [14:0] temp_centi_c;
    logic signed [15:0] temp_centi_f;
    logic        [13:0] humid_centi_pct;
  } hsfd_result_t;

  // CRC-8, MSB first, one byte
  function automatic logic [7:0] crc_feed(input logic [7:0] crc_in, input logic [7:0] data);
    logic [7:0] c;
    c = crc_in ^ data;
    for (int k = 0; k < 8; k++) begin
      c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

// ----- rtl/hsfd_fifo.sv -----
// Small first-word-fall-through queue with a register array.
module hsfd_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

endmodule

// ----- rtl/hsfd_front.sv -----
// Front end: byte position tracking, word assembly and CRC checking.
module hsfd_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  logic                 q_full,
  input  logic [7:0]           rx_byte,
  input  logic                 frame_start,
  input  logic                 check_crc,
  output logic                 frame_push,
  output hsfd_pkg::hsfd_frame_t frame_out
);
  import hsfd_pkg::*;

  logic [2:0]  position, position_next;
  logic [7:0]  crc_running, crc_running_next;
  logic        temp_crc_good, temp_crc_good_next;
  logic [15:0] temp_word, temp_word_next;
  logic [15:0] humid_word, humid_word_next;
  logic [2:0]  pos_eff;
  logic [7:0]  crc_base;
  logic        accept;

  assign accept = push && !q_full;

  always_comb begin
    pos_eff  = (frame_start || position > POS_HUMID_CRC) ? POS_TEMP_HI : position;
    crc_base = (pos_eff == POS_TEMP_HI) ? CRC_INIT : crc_running;

    position_next      = position;
    crc_running_next   = crc_running;
    temp_crc_good_next = temp_crc_good;
    temp_word_next     = temp_word;
    humid_word_next    = humid_word;
    frame_push         = 1'b0;

    frame_out.bad        = check_crc && (!temp_crc_good || crc_base != rx_byte);
    frame_out.temp_word  = temp_word;
    frame_out.humid_word = humid_word;

    if (accept) begin
      position_next    = (pos_eff == POS_HUMID_CRC) ? POS_TEMP_HI : pos_eff + 3'd1;
      crc_running_next = crc_base;
      unique case (pos_eff)
        POS_TEMP_HI: begin
          temp_crc_good_next = 1'b0;
          temp_word_next     = {rx_byte, 8'h00};
          crc_running_next   = crc_feed(CRC_INIT, rx_byte);
        end
        POS_TEMP_LO: begin
          temp_word_next   = {temp_word[15:8], rx_byte};
          crc_running_next = crc_feed(crc_base, rx_byte);
        end
        POS_TEMP_CRC: begin
          temp_crc_good_next = (crc_base == rx_byte);
          crc_running_next   = CRC_INIT;
        end
        POS_HUMID_HI: begin
          humid_word_next  = {rx_byte, 8'h00};
          crc_running_next = crc_feed(crc_base, rx_byte);
        end
        POS_HUMID_LO: begin
          humid_word_next  = {humid_word[15:8], rx_byte};
          crc_running_next = crc_feed(crc_base, rx_byte);
        end
        POS_HUMID_CRC: begin
          frame_push       = 1'b1;
          crc_running_next = CRC_INIT;
        end
        default: begin
          crc_running_next = crc_base;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position      <= POS_TEMP_HI;
      crc_running   <= CRC_INIT;
      temp_crc_good <= 1'b0;
      temp_word     <= '0;
      humid_word    <= '0;
    end else begin
      position      <= position_next;
      crc_running   <= crc_running_next;
      temp_crc_good <= temp_crc_good_next;
      temp_word     <= temp_word_next;
      humid_word    <= humid_word_next;
    end
  end

endmodule

// ----- rtl/hsfd_back.sv -----
// Back end: conversion pipeline, clamping and result queue.
module hsfd_back #(
  parameter int unsigned OUT_DEPTH = hsfd_pkg::OUT_DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  hsfd_pkg::hsfd_frame_t  frame_in,
  input  logic                   frame_empty,
  output logic                   frame_pop,
  input  hsfd_pkg::hsfd_cfg_t    cfg,
  output hsfd_pkg::hsfd_result_t res_out,
  output logic                   res_empty,
  input  logic                   res_pop
);
  import hsfd_pkg::*;

  localparam int unsigned RES_W = $clog2(OUT_DEPTH + 1);

  // Slots taken in the result queue plus transactions still in the pipeline
  logic [RES_W-1:0] reserved;
  logic             res_take;
  logic             res_full;

  // Stage 1: scale by constant
  logic        s1_valid, s1_bad;
  logic [15:0] s1_t, s1_h;
  logic [30:0] s1_pt;
  logic [29:0] s1_ph;
  // Stage 2: divide by 65535
  logic               s2_valid, s2_bad;
  logic [15:0]        s2_t, s2_h;
  logic signed [14:0] s2_c;
  logic [13:0]        s2_hp;
  // Stage 3: clamp, form |9C|
  logic               s3_valid, s3_bad, s3_neg;
  logic [15:0]        s3_t, s3_h;
  logic signed [14:0] s3_c;
  logic [13:0]        s3_hp;
  logic [17:0]        s3_m;
  // Stage 4: reciprocal multiply for /5
  logic               s4_valid, s4_bad, s4_neg;
  logic [15:0]        s4_t, s4_h;
  logic signed [14:0] s4_c;
  logic [13:0]        s4_hp;
  logic [33:0]        s4_prod;

  logic [31:0]        t_sum;
  logic [30:0]        h_sum;
  logic [15:0]        c_raw;
  logic signed [14:0] c_cl;
  logic [13:0]        h_cl;
  logic signed [18:0] c_ext, c9;
  logic [15:0]        f_mag;
  logic [15:0]        f_val;
  hsfd_result_t       res_in;

  assign frame_pop = !frame_empty && (reserved < RES_W'(OUT_DEPTH));
  assign res_take  = res_pop && !res_empty;

  always_comb begin
    t_sum = 32'(s1_pt) + 32'(s1_pt >> 16) + 32'd1;
    h_sum = 31'(s1_ph) + 31'(s1_ph >> 16) + 31'd1;
    c_raw = {1'b0, t_sum[30:16]} - 16'(TEMP_OFFSET);

    if (s2_c < cfg.temp_floor) begin
      c_cl = cfg.temp_floor;
    end else if (s2_c > cfg.temp_ceiling) begin
      c_cl = cfg.temp_ceiling;
    end else begin
      c_cl = s2_c;
    end
    if (s2_hp < cfg.humid_floor) begin
      h_cl = cfg.humid_floor;
    end else if (s2_hp > cfg.humid_ceiling) begin
      h_cl = cfg.humid_ceiling;
    end else begin
      h_cl = s2_hp;
    end
    c_ext = 19'(c_cl);
    c9    = (c_ext <<< 3) + c_ext;

    f_mag = s4_prod[DIV5_SHIFT +: 16];
    f_val = s4_neg ? 16'(F_OFFSET) - f_mag : 16'(F_OFFSET) + f_mag;

    if (s4_bad) begin
      res_in        = '0;
      res_in.status = 1'b1;
    end else begin
      res_in.status          = 1'b0;
      res_in.temp_ticks      = s4_t;
      res_in.humid_ticks     = s4_h;
      res_in.temp_centi_c    = s4_c;
      res_in.temp_centi_f    = f_val;
      res_in.humid_centi_pct = s4_hp;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
      reserved <= '0;
    end else begin
      s1_valid <= frame_pop;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
      case ({frame_pop, res_take})
        2'b10:   reserved <= reserved + 1'b1;
        2'b01:   reserved <= reserved - 1'b1;
        default: reserved <= reserved;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    s1_bad <= frame_in.bad;
    s1_t   <= frame_in.temp_word;
    s1_h   <= frame_in.humid_word;
    s1_pt  <= 31'(frame_in.temp_word) * 31'(TEMP_SCALE);
    s1_ph  <= 30'(frame_in.humid_word) * 30'(HUMID_SCALE);

    s2_bad <= s1_bad;
    s2_t   <= s1_t;
    s2_h   <= s1_h;
    s2_c   <= c_raw[14:0];
    s2_hp  <= h_sum[29:16];

    s3_bad <= s2_bad;
    s3_t   <= s2_t;
    s3_h   <= s2_h;
    s3_c   <= c_cl;
    s3_hp  <= h_cl;
    s3_neg <= c9[18];
    s3_m   <= c9[18] ? 18'(-c9) : 18'(c9);

    s4_bad  <= s3_bad;
    s4_t    <= s3_t;
    s4_h    <= s3_h;
    s4_c    <= s3_c;
    s4_hp   <= s3_hp;
    s4_neg  <= s3_neg;
    s4_prod <= 34'(s3_m) * 34'(DIV5_RECIP);
  end

  hsfd_fifo #(
    .WIDTH($bits(hsfd_result_t)),
    .DEPTH(OUT_DEPTH)
  ) u_res_q (
    .clk  (clk),
    .rst  (rst),
    .push (s4_valid),
    .wdata(res_in),
    .full (res_full),
    .pop  (res_take),
    .rdata(res_out),
    .empty(res_empty)
  );

endmodule

// ----- rtl/humidity_sensor_frame_decoder_core.sv -----
// Top level of the humidity sensor frame decoder: config registers, front, queue, back.
//
//  channel  | handshake                    | payload
//  ---------+------------------------------+--------------------------------------------
//  input    | push / full                  | rx_byte, frame_start
//  result   | empty / pop                  | status, temp_ticks, humid_ticks,
//           |                              | temp_centi_c, temp_centi_f, humid_centi_pct
//  config   | cfg_valid / cfg_ready        | cfg_index, cfg_data
//
// One byte is taken per cycle while full is low; the front end updates the frame state in the same cycle.
// After the frame's last byte is taken, the frame passes through the frame queue and the
// four-stage conversion pipeline (three constant multiplies) into the result queue.
// Reset is synchronous and clears positions, CRC state, queues and config to defaults.
// full rises only when the frame queue is full; the back end stalls on result-queue space.
module humidity_sensor_frame_decoder_core #(
  parameter int unsigned MID_DEPTH = hsfd_pkg::MID_DEPTH_DEF,
  parameter int unsigned OUT_DEPTH = hsfd_pkg::OUT_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  // input byte channel
  input  logic                              push,
  output logic                              full,
  input  logic [7:0]                        rx_byte,
  input  logic                              frame_start,
  // result channel
  output logic                              empty,
  input  logic                              pop,
  output logic                              status,
  output logic [15:0]                       temp_ticks,
  output logic [15:0]                       humid_ticks,
  output logic signed [14:0]                temp_centi_c,
  output logic signed [15:0]                temp_centi_f,
  output logic [13:0]                       humid_centi_pct,
  // config write channel
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [hsfd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [hsfd_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import hsfd_pkg::*;

  hsfd_cfg_t    cfg;
  hsfd_frame_t  frame_wr;
  hsfd_frame_t  frame_rd;
  hsfd_result_t res;
  logic         frame_push;
  logic         frame_pop;
  logic         mid_full;
  logic         mid_empty;

  // Config writes are always accepted.
  assign cfg_ready = 1'b1;

  // Decode the register index and hold the new value; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_CHECK_CRC:     cfg.check_crc     <= cfg_data[0];
        CFG_TEMP_FLOOR:    cfg.temp_floor    <= cfg_data[14:0];
        CFG_TEMP_CEILING:  cfg.temp_ceiling  <= cfg_data[14:0];
        CFG_HUMID_FLOOR:   cfg.humid_floor   <= cfg_data[13:0];
        CFG_HUMID_CEILING: cfg.humid_ceiling <= cfg_data[13:0];
        default:           cfg <= cfg;
      endcase
    end
  end

  // The input side backs up only when the frame queue cannot take a finished frame.
  assign full = mid_full;

  // Front: assemble words, run the CRC, flag bad frames.
  hsfd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .q_full     (mid_full),
    .rx_byte    (rx_byte),
    .frame_start(frame_start),
    .check_crc  (cfg.check_crc),
    .frame_push (frame_push),
    .frame_out  (frame_wr)
  );

  // Decouple the byte side from the conversion side.
  hsfd_fifo #(
    .WIDTH($bits(hsfd_frame_t)),
    .DEPTH(MID_DEPTH)
  ) u_frame_q (
    .clk  (clk),
    .rst  (rst),
    .push (frame_push),
    .wdata(frame_wr),
    .full (mid_full),
    .pop  (frame_pop),
    .rdata(frame_rd),
    .empty(mid_empty)
  );

  // Back: convert, clamp and queue results.
  hsfd_back #(
    .OUT_DEPTH(OUT_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .frame_in   (frame_rd),
    .frame_empty(mid_empty),
    .frame_pop  (frame_pop),
    .cfg        (cfg),
    .res_out    (res),
    .res_empty  (empty),
    .res_pop    (pop)
  );

  // Spread the head result onto the ports.
  assign status          = res.status;
  assign temp_ticks      = res.temp_ticks;
  assign humid_ticks     = res.humid_ticks;
  assign temp_centi_c    = res.temp_centi_c;
  assign temp_centi_f    = res.temp_centi_f;
  assign humid_centi_pct = res.humid_centi_pct;

endmodule

// ----- rtl/hsfd_checker.sv -----
// Port-level assertions for the frame decoder and their bind to the top level.
module hsfd_checker (
  input logic               clk,
  input logic               rst,
  input logic               full,
  input logic               empty,
  input logic               pop,
  input logic               status,
  input logic [15:0]        temp_ticks,
  input logic [15:0]        humid_ticks,
  input logic signed [14:0] temp_centi_c,
  input logic signed [15:0] temp_centi_f,
  input logic [13:0]        humid_centi_pct
);
  logic signed [20:0] f_err;

  // 9*C - 5*(F - 32.00) stays within the truncation window of the divide by five
  assign f_err = 21'(temp_centi_c) * 21'sd9 - (21'(temp_centi_f) - 21'sd3200) * 21'sd5;

  a_reset_clear: assert property (@(posedge clk) rst |=> empty && !full)
    else $error("queues not cleared by reset");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(status) && $stable(temp_ticks) && $stable(humid_ticks))
    else $error("waiting result changed before pop");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    !empty && status |-> temp_ticks == 16'd0 && humid_ticks == 16'd0 &&
      temp_centi_c == 15'sd0 && temp_centi_f == 16'sd0 && humid_centi_pct == 14'd0)
    else $error("error result carries nonzero data");

  a_fahrenheit: assert property (@(posedge clk) disable iff (rst)
    !empty && !status |-> f_err > -21'sd5 && f_err < 21'sd5)
    else $error("Fahrenheit does not follow Celsius");

endmodule

bind humidity_sensor_frame_decoder_core hsfd_checker u_hsfd_checker (.*);
